// ===== hw/rtl/oaht_pkg.sv =====
`default_nettype none
package oaht_pkg;

  typedef enum logic [2:0] {
    CMD_GET   = 3'd0,
    CMD_SET   = 3'd1,
    CMD_DEL   = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_NEXT  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    RES_OK   = 2'd0,
    RES_MISS = 2'd1,
    RES_FULL = 2'd2,
    RES_BAD  = 2'd3
  } res_e;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_ACTIVE  = 2'd1,
    ST_DELETED = 2'd2
  } slot_st_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] key;
    logic [31:0] value;
    logic [8:0]  position;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [31:0] key_out;
    logic [8:0]  next_position;
    logic [8:0]  active_count;
  } rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/oaht_status_mem.sv =====
`default_nettype none
// Slot status store. A per-slot valid bit tracks the clear epoch so that
// clear drops all slots at once; an invalid slot reads as unused.
module oaht_status_mem #(
  parameter int unsigned SLOTS = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clear_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [1:0]         rdata_o,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [1:0]    wdata_i
);
  import oaht_pkg::*;

  logic [1:0]       st_mem [SLOTS];
  logic [SLOTS-1:0] vld_q;
  logic [1:0]       rd_q;
  logic             rv_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      st_mem[waddr_i] <= wdata_i;
    end
    rd_q <= st_mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      rv_q <= vld_q[raddr_i] && !clear_i;
      if (clear_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = rv_q ? rd_q : 2'(ST_UNUSED);
endmodule
`default_nettype wire

// ===== hw/rtl/open_address_hash_table.sv =====
`default_nettype none
// Open-addressed key/value table with perturbed probing.
// Input channel req_valid_i/req_ready_o carries one command beat (get, set,
// delete, clear, next); output channel rsp_valid_o/rsp_ready_i returns one
// result beat per command. fill_wr_i/fill_data_i writes the fill limit;
// write it only while no command is in flight.
// Each probe reads the status, key and value memories (registered reads in
// S_READ) and then inspects the slot in S_CHECK. Set and delete pass through
// S_WRITE for the write-back when they change the table; every extra probe
// repeats S_READ and S_CHECK. A next scan walks one slot per probe from
// position to the next active slot, up to SLOTS slots. Clear, bad operands
// and a scan start past the table go from accept straight to the response
// state; clear drops all slots at once through per-slot valid bits. A new
// command is accepted only after the last one has left the response state.
// Reset empties the table, zeroes the counts and sets fill limit to 255.
// The output register holds the beat while rsp_ready_i is low; the next
// command is still accepted, runs until its own result is due and then
// waits in the response state until the output register frees up.
module open_address_hash_table #(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire oaht_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output oaht_pkg::rsp_t     rsp_o,
  input  wire logic          fill_wr_i,
  input  wire logic [7:0]    fill_data_i
);
  import oaht_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned NB = $clog2(SLOTS + 17);
  localparam logic [AW-1:0] MASK_MAX = AW'(SLOTS - 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_WRITE, S_RESP} state_e;

  state_e        state_q;
  req_t          req_q;
  logic [31:0]   perturb_q;
  logic [AW-1:0] idx_q;
  logic [NB-1:0] n_q;
  logic          free_seen_q;
  logic [AW-1:0] free_idx_q;
  logic [AW:0]   filled_q;
  logic [AW:0]   active_q;
  logic [7:0]    fill_limit_q;
  logic [AW:0]   scan_q;
  rsp_t          rsp_q;
  rsp_t          rsp_out_q;
  logic          rsp_valid_q;
  rsp_t          rsp_start;
  rsp_t          rsp_fin;
  // write-back
  logic          st_we_q;
  logic [1:0]    st_wd_q;
  logic          kv_we_q;
  logic          k_we_q;
  logic [AW-1:0] w_idx_q;

  logic [31:0]   key_mem [SLOTS];
  logic [31:0]   val_mem [SLOTS];
  logic [31:0]   key_rd_q, val_rd_q;
  logic [1:0]    st_rd;
  logic [AW-1:0] raddr;
  logic          clear_w;

  assign raddr   = idx_q;
  assign clear_w = (state_q == S_IDLE) && req_valid_i && req_ready_o &&
                   (req_i.cmd == CMD_CLEAR);

  oaht_status_mem #(.SLOTS(SLOTS), .AW(AW)) u_st (
    .clk_i, .rst_ni, .clear_i(clear_w), .raddr_i(raddr), .rdata_o(st_rd),
    .we_i(st_we_q), .waddr_i(w_idx_q), .wdata_i(st_wd_q)
  );

  always_ff @(posedge clk_i) begin
    if (kv_we_q) begin
      val_mem[w_idx_q] <= req_q.value;
      if (k_we_q) begin
        key_mem[w_idx_q] <= req_q.key;
      end
    end
    key_rd_q <= key_mem[raddr];
    val_rd_q <= val_mem[raddr];
  end

  // identity hash; all-ones key maps to all-ones minus one
  logic [31:0] hash_w;
  assign hash_w = (req_i.key == '1) ? 32'hFFFF_FFFE : req_i.key;

  logic [AW-1:0] limit_w;
  assign limit_w = (32'(fill_limit_q) > SLOTS - 1) ? MASK_MAX : AW'(fill_limit_q);

  // result seed at accept: operand checks, unknown codes and a scan start past the table
  always_comb begin
    rsp_start = '0;
    case (req_i.cmd)
      CMD_GET, CMD_DEL: begin
        if (req_i.key == '0) rsp_start.status = RES_BAD;
      end
      CMD_SET: begin
        if (req_i.key == '0 || req_i.value == '0) rsp_start.status = RES_BAD;
      end
      CMD_CLEAR: rsp_start.status = RES_OK;
      CMD_NEXT: begin
        if (req_i.position >= 9'(SLOTS)) begin
          rsp_start.status        = RES_MISS;
          rsp_start.next_position = 9'(SLOTS + 1);
        end
      end
      default: rsp_start.status = RES_BAD;
    endcase
  end

  always_comb begin
    rsp_fin              = rsp_q;
    rsp_fin.active_count = 9'(active_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      filled_q     <= '0;
      active_q     <= '0;
      fill_limit_q <= 8'd255;
      rsp_valid_q  <= 1'b0;
      st_we_q      <= 1'b0;
      kv_we_q      <= 1'b0;
      k_we_q       <= 1'b0;
      req_q        <= '0;
      rsp_q        <= '0;
      rsp_out_q    <= '0;
      perturb_q    <= '0;
      idx_q        <= '0;
      n_q          <= '0;
      free_seen_q  <= 1'b0;
      free_idx_q   <= '0;
      scan_q       <= '0;
      st_wd_q      <= '0;
      w_idx_q      <= '0;
    end else begin
      if (fill_wr_i) begin
        fill_limit_q <= fill_data_i;
      end
      if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i && req_ready_o) begin
            req_q       <= req_i;
            perturb_q   <= hash_w;
            idx_q       <= (req_i.cmd == CMD_NEXT) ? req_i.position[AW-1:0]
                                                   : AW'(hash_w);
            n_q         <= '0;
            free_seen_q <= 1'b0;
            rsp_q       <= rsp_start;
            scan_q      <= req_i.position[AW:0];
            case (req_i.cmd)
              CMD_CLEAR: begin
                filled_q <= '0;
                active_q <= '0;
                state_q  <= S_RESP;
              end
              CMD_GET, CMD_SET, CMD_DEL, CMD_NEXT: begin
                state_q <= (rsp_start.status == RES_OK) ? S_READ : S_RESP;
              end
              default: state_q <= S_RESP;
            endcase
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (req_q.cmd == CMD_NEXT) begin
            if (st_rd == ST_ACTIVE) begin
              rsp_q   <= '{status: RES_OK, value_out: val_rd_q, key_out: key_rd_q,
                           next_position: 9'(scan_q + 1'b1), active_count: 9'd0};
              state_q <= S_RESP;
            end else if (scan_q == (AW+1)'(SLOTS - 1)) begin
              rsp_q   <= '{status: RES_MISS, value_out: 32'd0, key_out: 32'd0,
                           next_position: 9'(SLOTS + 1), active_count: 9'd0};
              state_q <= S_RESP;
            end else begin
              scan_q  <= scan_q + 1'b1;
              idx_q   <= idx_q + 1'b1;
              state_q <= S_READ;
            end
          end else if (st_rd == ST_ACTIVE && key_rd_q == req_q.key) begin
            // hit
            w_idx_q <= idx_q;
            case (req_q.cmd)
              CMD_GET: begin
                rsp_q.value_out <= val_rd_q;
                state_q         <= S_RESP;
              end
              CMD_SET: begin
                kv_we_q <= 1'b1;
                state_q <= S_WRITE;
              end
              default: begin
                st_we_q  <= 1'b1;
                st_wd_q  <= ST_DELETED;
                active_q <= active_q - 1'b1;
                state_q  <= S_WRITE;
              end
            endcase
          end else if (st_rd == ST_UNUSED || n_q == NB'(SLOTS + 15)) begin
            // miss; pick insertion slot
            if (req_q.cmd != CMD_SET) begin
              rsp_q.status <= RES_MISS;
              state_q      <= S_RESP;
            end else if (free_seen_q) begin
              w_idx_q  <= free_idx_q;
              st_we_q  <= 1'b1;
              st_wd_q  <= ST_ACTIVE;
              kv_we_q  <= 1'b1;
              k_we_q   <= 1'b1;
              active_q <= active_q + 1'b1;
              state_q  <= S_WRITE;
            end else if (st_rd != ST_UNUSED ||
                         filled_q >= {1'b0, limit_w}) begin
              rsp_q.status <= RES_FULL;
              state_q      <= S_RESP;
            end else begin
              w_idx_q  <= idx_q;
              st_we_q  <= 1'b1;
              st_wd_q  <= ST_ACTIVE;
              kv_we_q  <= 1'b1;
              k_we_q   <= 1'b1;
              active_q <= active_q + 1'b1;
              filled_q <= filled_q + 1'b1;
              state_q  <= S_WRITE;
            end
          end else begin
            if (st_rd == ST_DELETED && !free_seen_q) begin
              free_seen_q <= 1'b1;
              free_idx_q  <= idx_q;
            end
            idx_q     <= AW'({idx_q, 2'b00} + idx_q + AW'(perturb_q) + 1'b1);
            perturb_q <= perturb_q >> 5;
            n_q       <= n_q + 1'b1;
            state_q   <= S_READ;
          end
        end
        S_WRITE: begin
          // write strobes are high for this one cycle only
          st_we_q <= 1'b0;
          kv_we_q <= 1'b0;
          k_we_q  <= 1'b0;
          state_q <= S_RESP;
        end
        S_RESP: begin
          // hold here until the output register is free
          if (!rsp_valid_q) begin
            rsp_out_q   <= rsp_fin;
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_out_q;

`ifndef NO_ASSERTIONS
  a_active_le_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= filled_q) else $error("active count above filled count");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req_ready_o) else $error("ready while busy");
  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q < (AW+1)'(SLOTS)) else $error("table filled past limit");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/open_address_hash_table_tb.sv =====
module open_address_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oaht_pkg::*;

  localparam int unsigned NSLOTS     = 256;
  localparam int unsigned STALL_CAP  = 20000;
  localparam int unsigned DRAIN_WAIT = 1200;

  logic clk_i;
  logic rst_ni;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rsp_t rsp_o;
  logic fill_wr_i;
  logic [7:0] fill_data_i;

  open_address_hash_table #(.SLOTS(NSLOTS)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .fill_wr_i   (fill_wr_i),
    .fill_data_i (fill_data_i)
  );

  // Shadow copy of the table, kept in step with every accepted command beat.
  slot_st_e    tbl_state [NSLOTS];
  logic [31:0] tbl_key   [NSLOTS];
  logic [31:0] tbl_val   [NSLOTS];
  int unsigned tbl_filled;
  int unsigned tbl_active;
  logic [7:0]  tbl_limit;

  req_t pending_cmds [$];
  rsp_t expected_rsps [$];
  int unsigned mismatches;
  bit   idle_off;
  int unsigned quiet_cycles;

  // Keys used so far, so random traffic keeps hitting live entries.
  logic [31:0] key_pool [$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Walk the perturbed probe sequence. found=1: key sits at idx.
  // Else has_slot tells whether idx is a slot an insert may fill.
  task automatic probe_table(input logic [31:0] k, output bit found,
                             output int unsigned idx, output bit has_slot);
    logic [31:0] h;
    logic [31:0] perturb;
    logic [7:0]  i;
    bit          del_seen;
    int unsigned del_idx;
    h        = (k == 32'hFFFF_FFFF) ? 32'hFFFF_FFFE : k;
    i        = h[7:0];
    perturb  = h;
    del_seen = 0;
    del_idx  = 0;
    found    = 0;
    has_slot = 0;
    idx      = 0;
    for (int n = 0; n < NSLOTS + 16; n++) begin
      if (tbl_state[i] == ST_UNUSED) begin
        idx      = del_seen ? del_idx : i;
        has_slot = 1;
        return;
      end
      if (tbl_state[i] == ST_ACTIVE && tbl_key[i] == k) begin
        idx = i; found = 1; has_slot = 1;
        return;
      end
      if (tbl_state[i] == ST_DELETED && !del_seen) begin
        del_seen = 1;
        del_idx  = i;
      end
      i       = 8'(5 * i + perturb + 1);
      perturb = perturb >> 5;
    end
    idx      = del_idx;
    has_slot = del_seen;
  endtask

  function automatic void clear_table();
    for (int s = 0; s < NSLOTS; s++) tbl_state[s] = ST_UNUSED;
    tbl_filled = 0;
    tbl_active = 0;
  endfunction

  // Compute the result beat for one command and update the shadow table.
  task automatic predict_table_op(input req_t r, output rsp_t o);
    bit          found;
    bit          has_slot;
    int unsigned idx;
    int unsigned cap;
    int unsigned s;
    cap = (tbl_limit < NSLOTS - 1) ? tbl_limit : NSLOTS - 1;
    o = '0;
    o.status = RES_OK;
    case (r.cmd)
      CMD_GET: begin
        if (r.key == 0) o.status = RES_BAD;
        else begin
          probe_table(r.key, found, idx, has_slot);
          if (found) o.value_out = tbl_val[idx];
          else o.status = RES_MISS;
        end
      end
      CMD_SET: begin
        if (r.key == 0 || r.value == 0) o.status = RES_BAD;
        else begin
          probe_table(r.key, found, idx, has_slot);
          if (found) tbl_val[idx] = r.value;
          else if (!has_slot) o.status = RES_FULL;
          else if (tbl_state[idx] == ST_DELETED) begin
            tbl_state[idx] = ST_ACTIVE;
            tbl_key[idx] = r.key;
            tbl_val[idx] = r.value;
            tbl_active++;
          end else if (tbl_filled >= cap) o.status = RES_FULL;
          else begin
            tbl_state[idx] = ST_ACTIVE;
            tbl_key[idx] = r.key;
            tbl_val[idx] = r.value;
            tbl_filled++;
            tbl_active++;
          end
        end
      end
      CMD_DEL: begin
        if (r.key == 0) o.status = RES_BAD;
        else begin
          probe_table(r.key, found, idx, has_slot);
          if (found) begin
            tbl_state[idx] = ST_DELETED;
            tbl_active--;
          end else o.status = RES_MISS;
        end
      end
      CMD_CLEAR: clear_table();
      CMD_NEXT: begin
        s = r.position;
        while (s < NSLOTS && tbl_state[s] != ST_ACTIVE) s++;
        if (s < NSLOTS) begin
          o.key_out = tbl_key[s];
          o.value_out = tbl_val[s];
          o.next_position = 9'(s + 1);
        end else begin
          o.status = RES_MISS;
          o.next_position = 9'(NSLOTS + 1);
        end
      end
      default: o.status = RES_BAD;
    endcase
    o.active_count = 9'(tbl_active);
  endtask

  function automatic req_t make_cmd(input cmd_e c, input logic [31:0] k,
                                    input logic [31:0] v, input logic [8:0] p);
    req_t r;
    r.cmd = c; r.key = k; r.value = v; r.position = p;
    return r;
  endfunction

  // Pick a key: mostly from the pool, sometimes a colliding or fresh one.
  function automatic logic [31:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55 && key_pool.size() > 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (sel < 75) return 32'({$urandom_range(0, 15), 8'($urandom_range(0, 3))});
    if (sel < 77) return 32'hFFFF_FFFF;
    if (sel < 79) return 32'hFFFF_FFFE;
    if (sel < 81) return 32'h0;
    return $urandom;
  endfunction

  function automatic req_t random_cmd();
    int unsigned sel;
    logic [31:0] k;
    logic [31:0] v;
    sel = $urandom_range(0, 999);
    k = pick_key();
    v = ($urandom_range(0, 49) == 0) ? 32'h0 : $urandom;
    if (k != 0 && key_pool.size() < 400) key_pool.push_back(k);
    if (sel < 400) return make_cmd(CMD_SET, k, v, 0);
    if (sel < 650) return make_cmd(CMD_GET, k, $urandom, 0);
    if (sel < 820) return make_cmd(CMD_DEL, k, $urandom, 0);
    if (sel < 960) return make_cmd(CMD_NEXT, $urandom, $urandom,
                                   9'($urandom_range(0, 511)));
    if (sel < 970) return make_cmd(CMD_CLEAR, $urandom, $urandom,
                                   9'($urandom));
    begin
      req_t r;
      r = make_cmd(CMD_GET, k, v, 9'($urandom));
      r.cmd = 3'($urandom_range(5, 7));
      return r;
    end
  endfunction

  // Mark the rising edges at which a command beat was accepted.
  bit req_fire;
  always @(posedge clk_i) req_fire <= rst_ni && req_valid_i && req_ready_o;

  // Driver: present the oldest pending beat, hold it until accepted.
  int unsigned src_gap;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_fire) begin
        void'(pending_cmds.pop_front());
        if (!idle_off && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 14);
      end
      if (req_valid_i && !req_fire) begin
        // hold the beat
      end else if (src_gap > 0) begin
        src_gap--;
        req_valid_i <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        req_valid_i <= 1'b1;
        req_i <= pending_cmds[0];
      end else req_valid_i <= 1'b0;
    end
  end

  // Receiver stalls in bursts.
  int unsigned sink_gap;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_gap > 0) begin
        sink_gap--;
        rsp_ready_i <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 13);
        rsp_ready_i <= 1'b0;
      end else rsp_ready_i <= 1'b1;
    end
  end

  // Monitor: predict on each accepted command, check each accepted result.
  always @(posedge clk_i) begin
    rsp_t want;
    bit   moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (req_valid_i && req_ready_o) begin
        predict_table_op(req_i, want);
        expected_rsps.push_back(want);
        moved = 1'b1;
      end
      if (rsp_valid_o && rsp_ready_i) begin
        moved = 1'b1;
        if (expected_rsps.size() == 0) report_mismatch("unexpected result", 0, 0);
        else begin
          want = expected_rsps.pop_front();
          if (rsp_o.status !== want.status)
            report_mismatch("status", 32'(rsp_o.status), 32'(want.status));
          if (rsp_o.value_out !== want.value_out)
            report_mismatch("value_out", rsp_o.value_out, want.value_out);
          if (rsp_o.key_out !== want.key_out)
            report_mismatch("key_out", rsp_o.key_out, want.key_out);
          if (rsp_o.next_position !== want.next_position)
            report_mismatch("next_position", 32'(rsp_o.next_position),
                            32'(want.next_position));
          if (rsp_o.active_count !== want.active_count)
            report_mismatch("active_count", 32'(rsp_o.active_count),
                            32'(want.active_count));
        end
      end
      if (moved) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_CAP) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Let all queued beats drain, then write the fill limit while idle.
  task automatic run_and_set_limit(input logic [7:0] lim);
    while (pending_cmds.size() > 0 || expected_rsps.size() > 0 || req_valid_i)
      @(posedge clk_i);
    @(negedge clk_i);
    fill_wr_i <= 1'b1;
    fill_data_i <= lim;
    @(negedge clk_i);
    fill_wr_i <= 1'b0;
    tbl_limit = lim;
  endtask

  task automatic queue_random(input int unsigned n);
    for (int j = 0; j < n; j++) pending_cmds.push_back(random_cmd());
  endtask

  initial begin
    rst_ni      = 1'b0;
    fill_wr_i   = 1'b0;
    fill_data_i = 8'd0;
    idle_off    = 0;
    tbl_limit   = 8'd255;
    clear_table();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: bad operands, unknown codes, extremes, colliding keys.
    pending_cmds.push_back(make_cmd(CMD_NEXT, 0, 0, 9'd0));
    pending_cmds.push_back(make_cmd(CMD_GET, 0, 1, 0));
    pending_cmds.push_back(make_cmd(CMD_SET, 0, 5, 0));
    pending_cmds.push_back(make_cmd(CMD_SET, 7, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_DEL, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    pending_cmds.push_back(make_cmd(CMD_SET, 32'hFFFF_FFFE, 32'h1, 0));
    pending_cmds.push_back(make_cmd(CMD_GET, 32'hFFFF_FFFF, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_SET, 32'h100, 32'hA5A5_5A5A, 0));
    pending_cmds.push_back(make_cmd(CMD_SET, 32'h200, 32'h5A5A_A5A5, 0));
    pending_cmds.push_back(make_cmd(CMD_DEL, 32'h100, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_GET, 32'h200, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_SET, 32'h300, 32'h3, 0));
    pending_cmds.push_back(make_cmd(CMD_SET, 32'h200, 32'h4, 0));
    pending_cmds.push_back(make_cmd(CMD_DEL, 32'h100, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_NEXT, 0, 0, 9'd0));
    pending_cmds.push_back(make_cmd(CMD_NEXT, 0, 0, 9'd255));
    pending_cmds.push_back(make_cmd(CMD_NEXT, 0, 0, 9'd257));
    pending_cmds.push_back(make_cmd(CMD_NEXT, 0, 0, 9'd511));
    begin
      req_t r;
      r = make_cmd(CMD_GET, 32'h1, 32'h1, 9'h1FF);
      r.cmd = 3'd7;
      pending_cmds.push_back(r);
    end
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF));
    pending_cmds.push_back(make_cmd(CMD_GET, 32'h200, 0, 0));

    // Tight fill limit: refusals, reuse of deleted slots, replace when full.
    run_and_set_limit(8'd1);
    pending_cmds.push_back(make_cmd(CMD_SET, 32'h11, 32'h1, 0));
    pending_cmds.push_back(make_cmd(CMD_SET, 32'h22, 32'h2, 0));
    pending_cmds.push_back(make_cmd(CMD_SET, 32'h11, 32'h9, 0));
    pending_cmds.push_back(make_cmd(CMD_DEL, 32'h11, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_SET, 32'h11, 32'h7, 0));
    queue_random(150);

    run_and_set_limit(8'd0);
    queue_random(100);
    run_and_set_limit(8'd20);
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0));
    queue_random(350);
    run_and_set_limit(8'd255);
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0));
    // Fill hard against the cap of SLOTS-1.
    for (int j = 0; j < 300; j++)
      pending_cmds.push_back(make_cmd(CMD_SET, $urandom | 32'h1, $urandom | 32'h1, 0));
    queue_random(300);
    run_and_set_limit(8'd128);
    queue_random(300);
    idle_off = 1;
    queue_random(200);

    while (pending_cmds.size() > 0 || expected_rsps.size() > 0 || req_valid_i)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
